@@ design/rth_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rth_pkg
// Types, constants and helper functions shared by the residue transition
// histogrammer and its submodules.
// ----------------------------------------------------------------------------
package rth_pkg;

  localparam int unsigned MIN_MOD_DEF        = 3;
  localparam int unsigned MAX_MOD_DEF        = 100;
  localparam int unsigned MAX_O2_MOD_DEF     = 50;
  localparam int unsigned DIFF_RANGE_DEF     = 1023;
  localparam int unsigned COUNT_WIDTH_DEF    = 32;

  localparam int unsigned NUM_STAT   = 14;
  localparam int unsigned MARG_DEPTH = 460;
  localparam int unsigned MODW       = 8;
  localparam int unsigned O2_MOD_LOW = 3;
  localparam logic [5:0]  O2_MOD_RST = 6'd10;

  localparam logic [MODW-1:0] STAT_MOD [NUM_STAT] = '{
    8'd3, 8'd4, 8'd5, 8'd7, 8'd8, 8'd9, 8'd11, 8'd12, 8'd15, 8'd16,
    8'd25, 8'd30, 8'd105, 8'd210
  };
  localparam logic [8:0] MARG_BASE [NUM_STAT] = '{
    9'd0, 9'd3, 9'd7, 9'd12, 9'd19, 9'd27, 9'd36, 9'd47, 9'd59, 9'd74,
    9'd90, 9'd115, 9'd145, 9'd250
  };

  localparam logic CFG_O2_MOD = 1'b0;
  localparam logic CFG_TRAIN  = 1'b1;

  localparam logic [18:0] SCL_COUNT = 19'd0;
  localparam logic [18:0] SCL_MIN   = 19'd1;
  localparam logic [18:0] SCL_MAX   = 19'd2;
  localparam logic [18:0] SCL_STEPS = 19'd3;
  localparam logic [18:0] SCL_OVF   = 19'd4;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } rth_cmd_e;

  typedef enum logic [2:0] {
    SEL_MARG   = 3'd0,
    SEL_DIFF   = 3'd1,
    SEL_TOBS   = 3'd2,
    SEL_TTRN   = 3'd3,
    SEL_XOBS   = 3'd4,
    SEL_XTRN   = 3'd5,
    SEL_SCALAR = 3'd6
  } rth_sel_e;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MARG_GO,
    ST_MARG_WAIT,
    ST_DIFF,
    ST_DIFF_SEL,
    ST_TR_GO,
    ST_TR_WAIT,
    ST_O2_GO,
    ST_O2_WAIT,
    ST_O2_ADDR,
    ST_RMW_RD,
    ST_RMW_WR,
    ST_FINISH,
    ST_RD_SQ,
    ST_RD_CUBE,
    ST_RD_ISSUE,
    ST_RD_DATA
  } rth_state_e;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [63:0] term;
    logic [2:0]         table_select;
    logic [18:0]        counter_index;
  } rth_in_t;

  typedef struct packed {
    logic [63:0] read_data;
    logic        index_error;
  } rth_out_t;

  typedef struct packed {
    logic            start;
    logic            neg;
    logic [63:0]     mag;
    logic [MODW-1:0] modulus;
  } rth_res_req_t;

  typedef struct packed {
    logic            done;
    logic [MODW-1:0] residue;
  } rth_res_rsp_t;

  function automatic int unsigned sum_sq(int unsigned n);
    return n * (n + 1) * (2 * n + 1) / 6;
  endfunction

endpackage
`default_nettype wire

@@ design/rth_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rth_ram
// Generic RAM with one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module rth_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ design/rth_residue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rth_residue
// Non-negative residue of a signed 64-bit term by a small modulus, eight
// bits of the magnitude per cycle.
// ----------------------------------------------------------------------------
module rth_residue (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire rth_pkg::rth_res_req_t req_i,
  output rth_pkg::rth_res_rsp_t      rsp_o
);
  import rth_pkg::*;

  logic            busy_q, done_q;
  logic [2:0]      cnt_q;
  logic [63:0]     sh_q;
  logic [MODW-1:0] r_q, mod_q, res_q;
  logic            neg_q;
  logic [MODW:0]   acc;

  always_comb begin
    acc = {1'b0, r_q};
    for (int k = 0; k < 8; k++) begin
      acc = {acc[MODW-1:0], sh_q[63-k]};
      if (acc >= {1'b0, mod_q}) begin
        acc = acc - {1'b0, mod_q};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == 3'd7) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      sh_q  <= req_i.mag;
      r_q   <= '0;
      mod_q <= req_i.modulus;
      neg_q <= req_i.neg;
    end else if (busy_q) begin
      sh_q <= {sh_q[55:0], 8'd0};
      r_q  <= acc[MODW-1:0];
      if (neg_q && (acc != '0)) begin
        res_q <= mod_q - acc[MODW-1:0];
      end else begin
        res_q <= acc[MODW-1:0];
      end
    end
  end

  assign rsp_o.done    = done_q;
  assign rsp_o.residue = res_q;

endmodule
`default_nettype wire

@@ design/residue_transition_histogrammer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// residue_transition_histogrammer
// Residue, difference and transition histograms over a stream of terms,
// with all counter tables held in one shared RAM.
// ----------------------------------------------------------------------------
// A push keeps busy high while the residue unit computes its 113 residues, one
// after another, plus a read-modify-write per counter increment. A read passes
// through ST_RD_SQ, ST_RD_CUBE, ST_RD_ISSUE and, for a RAM table, ST_RD_DATA;
// a no-op leaves busy low; the beat follows. Clear and reset run a pass over
// the whole RAM, one entry a cycle; busy is high throughout.
// Each result is a one-cycle beat on result_valid_o; the receiver cannot stall.
module residue_transition_histogrammer #(
  parameter int unsigned MIN_MOD     = rth_pkg::MIN_MOD_DEF,
  parameter int unsigned MAX_MOD     = rth_pkg::MAX_MOD_DEF,
  parameter int unsigned MAX_O2_MOD  = rth_pkg::MAX_O2_MOD_DEF,
  parameter int unsigned DIFF_RANGE  = rth_pkg::DIFF_RANGE_DEF,
  parameter int unsigned COUNT_WIDTH = rth_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire rth_pkg::rth_in_t in_i,
  output logic                  result_valid_o,
  output rth_pkg::rth_out_t     result_o,
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_index_i,
  input  wire logic [31:0]      cfg_data_i
);
  import rth_pkg::*;

  localparam int unsigned CW           = COUNT_WIDTH;
  localparam int unsigned NRES         = MAX_MOD - MIN_MOD + 1;
  localparam int unsigned RES_W        = $clog2(MAX_MOD);
  localparam int unsigned O2RW         = $clog2(MAX_O2_MOD);
  localparam int unsigned TRANS_DEPTH  = sum_sq(MAX_MOD) - sum_sq(MIN_MOD - 1);
  localparam int unsigned TRIPLE_DEPTH = MAX_O2_MOD * MAX_O2_MOD * MAX_O2_MOD;
  localparam int unsigned DIFF_DEPTH   = 2 * DIFF_RANGE + 1;
  localparam int unsigned DIFF_OFF     = MARG_DEPTH;
  localparam int unsigned TOBS_OFF     = DIFF_OFF + DIFF_DEPTH;
  localparam int unsigned TTRN_OFF     = TOBS_OFF + TRANS_DEPTH;
  localparam int unsigned XOBS_OFF     = TTRN_OFF + TRANS_DEPTH;
  localparam int unsigned XTRN_OFF     = XOBS_OFF + TRIPLE_DEPTH;
  localparam int unsigned TOTAL_DEPTH  = XTRN_OFF + TRIPLE_DEPTH;
  localparam int unsigned AW           = $clog2(TOTAL_DEPTH);

  rth_state_e        state_q, state_d, ret_q, ret_d;
  rth_in_t           in_q, in_d;
  logic [63:0]       mag_q, mag_d;
  logic              train_q, train_d;
  logic [5:0]        o2_mod_q;
  logic [31:0]       train_lim_q;
  logic [63:0]       prev_term_q, prev_term_d;
  logic [31:0]       term_cnt_q, term_cnt_d;
  logic [RES_W-1:0]  prev_res_q [NRES];
  logic [RES_W-1:0]  prev_res_d [NRES];
  logic [O2RW-1:0]   o2_last_q, o2_last_d, o2_earl_q, o2_earl_d;
  logic [CW-1:0]     steps_q, steps_d, ovf_q, ovf_d;
  logic [63:0]       min_q, min_d, max_q, max_d;
  logic [3:0]        i_q, i_d;
  logic [MODW-1:0]   q_q, q_d, q2_q, q2_d;
  logic [AW-1:0]     tbase_q, tbase_d, inc_addr_q, inc_addr_d, addr2_q, addr2_d;
  logic [AW-1:0]     clr_addr_q, clr_addr_d;
  logic              second_q, second_d, up_q, up_d, clr_cmd_q, clr_cmd_d;
  logic [63:0]       dmag_q, dmag_d;
  logic [O2RW-1:0]   r2_q, r2_d;
  logic [15:0]       part_q, part_d, sq_q, sq_d;
  logic [23:0]       cube_q, cube_d;
  rth_out_t          out_q, out_d;
  logic              out_valid_q, out_valid_d;

  rth_res_req_t      res_req;
  rth_res_rsp_t      res_rsp;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [CW-1:0]     ram_wdata, ram_rdata;

  logic [MODW-1:0]   q2_eff;
  logic [7:0]        o2_ext;
  logic              rd_mem, rd_ok;
  logic [AW-1:0]     rd_addr;
  logic [63:0]       rd_scalar;
  logic [AW-1:0]     tr_addr, x_addr;
  logic [15:0]       tr_prod;
  logic              tr_last;

  rth_residue u_residue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (res_req),
    .rsp_o  (res_rsp)
  );

  rth_ram #(
    .WIDTH (CW),
    .DEPTH (TOTAL_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    o2_ext = {2'b00, o2_mod_q};
    if (o2_ext < 8'(O2_MOD_LOW)) begin
      q2_eff = MODW'(O2_MOD_LOW);
    end else if (o2_ext > 8'(MAX_O2_MOD)) begin
      q2_eff = MODW'(MAX_O2_MOD);
    end else begin
      q2_eff = o2_ext;
    end
  end

  assign tr_prod = 16'(prev_res_q[0]) * 16'(q_q);
  assign tr_addr = AW'(TOBS_OFF) + tbase_q + AW'(tr_prod) + AW'(res_rsp.residue);
  assign tr_last = (q_q == MODW'(MAX_MOD));
  assign x_addr  = AW'(XOBS_OFF) + AW'(24'(part_q) * 24'(q2_q) + 24'(r2_q));

  // Read decode.
  always_comb begin
    rd_mem    = 1'b0;
    rd_ok     = 1'b0;
    rd_addr   = '0;
    rd_scalar = '0;
    unique case (rth_sel_e'(in_q.table_select))
      SEL_MARG: begin
        rd_mem  = 1'b1;
        rd_ok   = 32'(in_q.counter_index) < 32'(MARG_DEPTH);
        rd_addr = AW'(in_q.counter_index);
      end
      SEL_DIFF: begin
        rd_mem  = 1'b1;
        rd_ok   = 32'(in_q.counter_index) < 32'(DIFF_DEPTH);
        rd_addr = AW'(DIFF_OFF) + AW'(in_q.counter_index);
      end
      SEL_TOBS: begin
        rd_mem  = 1'b1;
        rd_ok   = 32'(in_q.counter_index) < 32'(TRANS_DEPTH);
        rd_addr = AW'(TOBS_OFF) + AW'(in_q.counter_index);
      end
      SEL_TTRN: begin
        rd_mem  = 1'b1;
        rd_ok   = 32'(in_q.counter_index) < 32'(TRANS_DEPTH);
        rd_addr = AW'(TTRN_OFF) + AW'(in_q.counter_index);
      end
      SEL_XOBS: begin
        rd_mem  = 1'b1;
        rd_ok   = 24'(in_q.counter_index) < cube_q;
        rd_addr = AW'(XOBS_OFF) + AW'(in_q.counter_index);
      end
      SEL_XTRN: begin
        rd_mem  = 1'b1;
        rd_ok   = 24'(in_q.counter_index) < cube_q;
        rd_addr = AW'(XTRN_OFF) + AW'(in_q.counter_index);
      end
      SEL_SCALAR: begin
        rd_ok = 1'b1;
        unique case (in_q.counter_index)
          SCL_COUNT: rd_scalar = 64'(term_cnt_q);
          SCL_MIN:   rd_scalar = min_q;
          SCL_MAX:   rd_scalar = max_q;
          SCL_STEPS: rd_scalar = 64'(steps_q);
          SCL_OVF:   rd_scalar = 64'(ovf_q);
          default:   rd_ok = 1'b0;
        endcase
      end
      default: begin
        rd_ok = 1'b0;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_addr_q == AW'(TOTAL_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          unique case (rth_cmd_e'(in_i.cmd))
            CMD_PUSH:  state_d = ST_MARG_GO;
            CMD_READ:  state_d = ST_RD_SQ;
            CMD_CLEAR: state_d = ST_CLEAR;
            CMD_NOP:   state_d = ST_IDLE;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_MARG_GO:   state_d = ST_MARG_WAIT;
      ST_MARG_WAIT: begin
        if (res_rsp.done) begin
          state_d = ST_RMW_RD;
        end
      end
      ST_DIFF: begin
        state_d = (term_cnt_q == '0) ? ST_TR_GO : ST_DIFF_SEL;
      end
      ST_DIFF_SEL: begin
        state_d = (dmag_q <= 64'(DIFF_RANGE)) ? ST_RMW_RD : ST_TR_GO;
      end
      ST_TR_GO:     state_d = ST_TR_WAIT;
      ST_TR_WAIT: begin
        if (res_rsp.done) begin
          if (term_cnt_q != '0) begin
            state_d = ST_RMW_RD;
          end else begin
            state_d = tr_last ? ST_O2_GO : ST_TR_GO;
          end
        end
      end
      ST_O2_GO:     state_d = ST_O2_WAIT;
      ST_O2_WAIT: begin
        if (res_rsp.done) begin
          state_d = ST_O2_ADDR;
        end
      end
      ST_O2_ADDR: begin
        state_d = (term_cnt_q > 32'd1) ? ST_RMW_RD : ST_FINISH;
      end
      ST_RMW_RD:    state_d = ST_RMW_WR;
      ST_RMW_WR: begin
        state_d = second_q ? ST_RMW_RD : ret_q;
      end
      ST_FINISH:    state_d = ST_IDLE;
      ST_RD_SQ:     state_d = ST_RD_CUBE;
      ST_RD_CUBE:   state_d = ST_RD_ISSUE;
      ST_RD_ISSUE: begin
        state_d = (rd_mem && rd_ok) ? ST_RD_DATA : ST_IDLE;
      end
      ST_RD_DATA:   state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    ret_d       = ret_q;
    in_d        = in_q;
    mag_d       = mag_q;
    train_d     = train_q;
    prev_term_d = prev_term_q;
    term_cnt_d  = term_cnt_q;
    prev_res_d  = prev_res_q;
    o2_last_d   = o2_last_q;
    o2_earl_d   = o2_earl_q;
    steps_d     = steps_q;
    ovf_d       = ovf_q;
    min_d       = min_q;
    max_d       = max_q;
    i_d         = i_q;
    q_d         = q_q;
    q2_d        = q2_q;
    tbase_d     = tbase_q;
    inc_addr_d  = inc_addr_q;
    addr2_d     = addr2_q;
    clr_addr_d  = clr_addr_q;
    second_d    = second_q;
    up_d        = up_q;
    clr_cmd_d   = clr_cmd_q;
    dmag_d      = dmag_q;
    r2_d        = r2_q;
    part_d      = part_q;
    sq_d        = sq_q;
    cube_d      = cube_q;
    out_d       = out_q;
    out_valid_d = 1'b0;
    res_req     = '0;
    res_req.mag = mag_q;
    res_req.neg = in_q.term[63];
    ram_we      = 1'b0;
    ram_waddr   = inc_addr_q;
    ram_wdata   = (&ram_rdata) ? ram_rdata : ram_rdata + CW'(1);
    ram_raddr   = inc_addr_q;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we     = 1'b1;
        ram_waddr  = clr_addr_q;
        ram_wdata  = '0;
        clr_addr_d = clr_addr_q + AW'(1);
        if (clr_addr_q == AW'(TOTAL_DEPTH - 1)) begin
          out_d       = '0;
          out_valid_d = clr_cmd_q;
        end
      end
      ST_IDLE: begin
        if (start) begin
          in_d    = in_i;
          mag_d   = in_i.term[63] ? 64'd0 - 64'(in_i.term) : 64'(in_i.term);
          train_d = term_cnt_q <= train_lim_q;
          i_d     = '0;
          unique case (rth_cmd_e'(in_i.cmd))
            CMD_CLEAR: begin
              clr_addr_d  = '0;
              clr_cmd_d   = 1'b1;
              prev_term_d = '0;
              term_cnt_d  = '0;
              for (int k = 0; k < NRES; k++) begin
                prev_res_d[k] = '0;
              end
              o2_last_d = '0;
              o2_earl_d = '0;
              steps_d   = '0;
              ovf_d     = '0;
              min_d     = 64'h7FFF_FFFF_FFFF_FFFF;
              max_d     = 64'h8000_0000_0000_0000;
            end
            CMD_NOP: begin
              out_d       = '0;
              out_valid_d = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_MARG_GO: begin
        res_req.start   = 1'b1;
        res_req.modulus = STAT_MOD[i_q];
      end
      ST_MARG_WAIT: begin
        if (res_rsp.done) begin
          inc_addr_d = AW'(MARG_BASE[i_q]) + AW'(res_rsp.residue);
          second_d   = 1'b0;
          ret_d      = (i_q == 4'(NUM_STAT - 1)) ? ST_DIFF : ST_MARG_GO;
          i_d        = i_q + 4'd1;
        end
      end
      ST_DIFF: begin
        q_d     = MODW'(MIN_MOD);
        tbase_d = '0;
        up_d    = in_q.term > $signed(prev_term_q);
        dmag_d  = up_d ? 64'(in_q.term) - prev_term_q : prev_term_q - 64'(in_q.term);
      end
      ST_DIFF_SEL: begin
        if (up_q && !(&steps_q)) begin
          steps_d = steps_q + CW'(1);
        end
        if (dmag_q <= 64'(DIFF_RANGE)) begin
          inc_addr_d = up_q ? AW'(DIFF_OFF + DIFF_RANGE) + AW'(dmag_q)
                            : AW'(DIFF_OFF + DIFF_RANGE) - AW'(dmag_q);
          second_d   = 1'b0;
          ret_d      = ST_TR_GO;
        end else if (!(&ovf_q)) begin
          ovf_d = ovf_q + CW'(1);
        end
      end
      ST_TR_GO: begin
        res_req.start   = 1'b1;
        res_req.modulus = q_q;
      end
      ST_TR_WAIT: begin
        if (res_rsp.done) begin
          for (int k = 0; k < NRES - 1; k++) begin
            prev_res_d[k] = prev_res_q[k+1];
          end
          prev_res_d[NRES-1] = RES_W'(res_rsp.residue);
          tbase_d    = tbase_q + AW'(16'(q_q) * 16'(q_q));
          q_d        = q_q + MODW'(1);
          inc_addr_d = tr_addr;
          addr2_d    = tr_addr + AW'(TRANS_DEPTH);
          second_d   = train_q;
          ret_d      = tr_last ? ST_O2_GO : ST_TR_GO;
        end
      end
      ST_O2_GO: begin
        res_req.start   = 1'b1;
        res_req.modulus = q2_eff;
        q2_d            = q2_eff;
      end
      ST_O2_WAIT: begin
        if (res_rsp.done) begin
          r2_d   = O2RW'(res_rsp.residue);
          part_d = 16'(o2_earl_q) * 16'(q2_q) + 16'(o2_last_q);
        end
      end
      ST_O2_ADDR: begin
        inc_addr_d = x_addr;
        addr2_d    = x_addr + AW'(TRIPLE_DEPTH);
        second_d   = train_q;
        ret_d      = ST_FINISH;
      end
      ST_RMW_RD: begin
        ram_raddr = inc_addr_q;
      end
      ST_RMW_WR: begin
        ram_we = 1'b1;
        if (second_q) begin
          inc_addr_d = addr2_q;
          second_d   = 1'b0;
        end
      end
      ST_FINISH: begin
        if (in_q.term < $signed(min_q)) begin
          min_d = 64'(in_q.term);
        end
        if (in_q.term > $signed(max_q)) begin
          max_d = 64'(in_q.term);
        end
        prev_term_d = 64'(in_q.term);
        if (!(&term_cnt_q)) begin
          term_cnt_d = term_cnt_q + 32'd1;
        end
        o2_earl_d   = o2_last_q;
        o2_last_d   = r2_q;
        out_d       = '0;
        out_valid_d = 1'b1;
      end
      ST_RD_SQ: begin
        sq_d = 16'(q2_eff) * 16'(q2_eff);
      end
      ST_RD_CUBE: begin
        cube_d = 24'(sq_q) * 24'(q2_eff);
      end
      ST_RD_ISSUE: begin
        ram_raddr = rd_addr;
        if (!(rd_mem && rd_ok)) begin
          out_d.read_data   = rd_ok ? rd_scalar : 64'd0;
          out_d.index_error = !rd_ok;
          out_valid_d       = 1'b1;
        end
      end
      ST_RD_DATA: begin
        out_d.read_data   = 64'(ram_rdata);
        out_d.index_error = 1'b0;
        out_valid_d       = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      ret_q       <= ST_IDLE;
      o2_mod_q    <= O2_MOD_RST;
      train_lim_q <= '0;
      prev_term_q <= '0;
      term_cnt_q  <= '0;
      for (int k = 0; k < NRES; k++) begin
        prev_res_q[k] <= '0;
      end
      o2_last_q   <= '0;
      o2_earl_q   <= '0;
      steps_q     <= '0;
      ovf_q       <= '0;
      min_q       <= 64'h7FFF_FFFF_FFFF_FFFF;
      max_q       <= 64'h8000_0000_0000_0000;
      i_q         <= '0;
      second_q    <= 1'b0;
      clr_addr_q  <= '0;
      clr_cmd_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_O2_MOD) begin
          o2_mod_q <= cfg_data_i[5:0];
        end else if (cfg_index_i == CFG_TRAIN) begin
          train_lim_q <= cfg_data_i;
        end
      end
      prev_term_q <= prev_term_d;
      term_cnt_q  <= term_cnt_d;
      prev_res_q  <= prev_res_d;
      o2_last_q   <= o2_last_d;
      o2_earl_q   <= o2_earl_d;
      steps_q     <= steps_d;
      ovf_q       <= ovf_d;
      min_q       <= min_d;
      max_q       <= max_d;
      i_q         <= i_d;
      second_q    <= second_d;
      clr_addr_q  <= clr_addr_d;
      clr_cmd_q   <= clr_cmd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q       <= in_d;
    mag_q      <= mag_d;
    train_q    <= train_d;
    q_q        <= q_d;
    q2_q       <= q2_d;
    tbase_q    <= tbase_d;
    inc_addr_q <= inc_addr_d;
    addr2_q    <= addr2_d;
    up_q       <= up_d;
    dmag_q     <= dmag_d;
    r2_q       <= r2_d;
    part_q     <= part_d;
    sq_q       <= sq_d;
    cube_q     <= cube_d;
    out_q      <= out_d;
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = out_valid_q;
  assign result_o       = out_q;

endmodule
`default_nettype wire

@@ sim/tb_residue_transition_histogrammer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_residue_transition_histogrammer
// Self-checking bench for the residue transition histogrammer. Commands are
// queued by a stimulus process and issued by a clocked driver. The counter
// stores are predicted in arrays, sparse ones for the transition and triple
// tables, and every result beat is compared with the oldest predicted beat.
// ----------------------------------------------------------------------------
module tb_residue_transition_histogrammer;
  import rth_pkg::*;

  localparam int unsigned TRANS_SPAN = 338345;
  localparam int unsigned DIFF_SPAN  = 2047;
  localparam logic [31:0] CNT_TOP    = 32'hFFFF_FFFF;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  rth_in_t     in_i = '0;
  logic        result_valid_o;
  rth_out_t    result_o;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = 1'b0;
  logic [31:0] cfg_data_i = '0;

  residue_transition_histogrammer dut (
    .clk_i, .rst_ni, .start, .busy, .in_i, .result_valid_o, .result_o,
    .cfg_we_i, .cfg_index_i, .cfg_data_i
  );

  always #1 clk_i = ~clk_i;

  // Predicted state of the block.
  logic [5:0]  o2_mod_reg;
  logic [31:0] train_lim_reg;
  logic [63:0] last_term;
  logic [31:0] terms_seen;
  logic [6:0]  last_res [MIN_MOD_DEF:MAX_MOD_DEF];
  int unsigned o2_last, o2_earlier;
  logic [31:0] marg_cnt [MARG_DEPTH];
  logic [31:0] diff_cnt [DIFF_SPAN];
  logic [31:0] trans_obs [int unsigned];
  logic [31:0] trans_trn [int unsigned];
  logic [31:0] triple_obs [int unsigned];
  logic [31:0] triple_trn [int unsigned];
  logic [31:0] up_steps, diff_ovf;
  logic [63:0] min_term, max_term;
  int unsigned hot_addr [8];

  rth_in_t  pending_cmds [$];
  rth_out_t expected_reads [$];
  int       idle_pct = 0;
  int       errors = 0;
  int       n_push = 0, n_read = 0, n_other = 0;
  logic [63:0] gen_prev = '0;

  function automatic void queue_cmd(rth_in_t it);
    pending_cmds.insert(pending_cmds.size(), it);
  endfunction

  function automatic void expect_beat(rth_out_t o);
    expected_reads.insert(expected_reads.size(), o);
  endfunction

  function automatic logic [31:0] sat_inc(logic [31:0] c);
    return (c == CNT_TOP) ? c : c + 32'd1;
  endfunction

  function automatic int unsigned residue(logic [63:0] raw, int unsigned m);
    logic [63:0] mg;
    int unsigned r;
    if (!raw[63]) return int'(raw % m);
    mg = -raw;
    r = int'(mg % m);
    return (r != 0) ? m - r : 0;
  endfunction

  function automatic int unsigned o2_eff();
    int unsigned q;
    q = o2_mod_reg;
    if (q < O2_MOD_LOW) q = O2_MOD_LOW;
    if (q > MAX_O2_MOD_DEF) q = MAX_O2_MOD_DEF;
    return q;
  endfunction

  function automatic void clear_stores();
    last_term = '0;
    terms_seen = '0;
    foreach (last_res[q]) last_res[q] = '0;
    o2_last = 0;
    o2_earlier = 0;
    foreach (marg_cnt[i]) marg_cnt[i] = '0;
    foreach (diff_cnt[i]) diff_cnt[i] = '0;
    trans_obs.delete();
    trans_trn.delete();
    triple_obs.delete();
    triple_trn.delete();
    up_steps = '0;
    diff_ovf = '0;
    min_term = 64'h7FFF_FFFF_FFFF_FFFF;
    max_term = 64'h8000_0000_0000_0000;
  endfunction

  function automatic void bump_sparse(ref logic [31:0] tbl [int unsigned], input int unsigned a);
    tbl[a] = sat_inc(tbl.exists(a) ? tbl[a] : '0);
  endfunction

  function automatic void push_term(logic [63:0] x);
    int unsigned idx, base, r, q2, a;
    logic trn, up;
    logic [63:0] bx, bp, mag;
    idx = terms_seen;
    trn = (terms_seen <= train_lim_reg);
    if ($signed(x) < $signed(min_term)) min_term = x;
    if ($signed(x) > $signed(max_term)) max_term = x;
    base = 0;
    for (int i = 0; i < NUM_STAT; i++) begin
      a = base + residue(x, STAT_MOD[i]);
      marg_cnt[a] = sat_inc(marg_cnt[a]);
      hot_addr[SEL_MARG] = a;
      base += STAT_MOD[i];
    end
    if (idx >= 1) begin
      bx = x ^ 64'h8000_0000_0000_0000;
      bp = last_term ^ 64'h8000_0000_0000_0000;
      up = bx > bp;
      mag = up ? bx - bp : bp - bx;
      if (up) up_steps = sat_inc(up_steps);
      if (mag <= DIFF_RANGE_DEF) begin
        a = up ? DIFF_RANGE_DEF + int'(mag) : DIFF_RANGE_DEF - int'(mag);
        diff_cnt[a] = sat_inc(diff_cnt[a]);
        hot_addr[SEL_DIFF] = a;
      end else begin
        diff_ovf = sat_inc(diff_ovf);
      end
    end
    base = 0;
    for (int unsigned q = MIN_MOD_DEF; q <= MAX_MOD_DEF; q++) begin
      r = residue(x, q);
      if (idx >= 1) begin
        a = base + last_res[q] * q + r;
        bump_sparse(trans_obs, a);
        if (trn) bump_sparse(trans_trn, a);
        if ($urandom_range(0, 20) == 0) hot_addr[SEL_TOBS] = a;
      end
      last_res[q] = r[6:0];
      base += q * q;
    end
    q2 = o2_eff();
    r = residue(x, q2);
    if (idx >= 2) begin
      a = (o2_earlier * q2 + o2_last) * q2 + r;
      if (a < MAX_O2_MOD_DEF ** 3) begin
        bump_sparse(triple_obs, a);
        if (trn) bump_sparse(triple_trn, a);
        hot_addr[SEL_XOBS] = a;
      end
    end
    o2_earlier = o2_last;
    o2_last = r;
    last_term = x;
    if (terms_seen != CNT_TOP) terms_seen++;
  endfunction

  function automatic rth_out_t read_counter(logic [2:0] sel, logic [18:0] ci);
    rth_out_t o;
    int unsigned i, q;
    o = '0;
    i = ci;
    q = o2_eff();
    o.index_error = 1'b0;
    case (sel)
      SEL_MARG:   if (i < MARG_DEPTH) o.read_data = marg_cnt[i]; else o.index_error = 1'b1;
      SEL_DIFF:   if (i < DIFF_SPAN) o.read_data = diff_cnt[i]; else o.index_error = 1'b1;
      SEL_TOBS:   if (i < TRANS_SPAN) o.read_data = trans_obs.exists(i) ? trans_obs[i] : '0;
                  else o.index_error = 1'b1;
      SEL_TTRN:   if (i < TRANS_SPAN) o.read_data = trans_trn.exists(i) ? trans_trn[i] : '0;
                  else o.index_error = 1'b1;
      SEL_XOBS:   if (i < q * q * q) o.read_data = triple_obs.exists(i) ? triple_obs[i] : '0;
                  else o.index_error = 1'b1;
      SEL_XTRN:   if (i < q * q * q) o.read_data = triple_trn.exists(i) ? triple_trn[i] : '0;
                  else o.index_error = 1'b1;
      SEL_SCALAR: begin
        case (ci)
          SCL_COUNT: o.read_data = terms_seen;
          SCL_MIN:   o.read_data = min_term;
          SCL_MAX:   o.read_data = max_term;
          SCL_STEPS: o.read_data = up_steps;
          SCL_OVF:   o.read_data = diff_ovf;
          default:   o.index_error = 1'b1;
        endcase
      end
      default: o.index_error = 1'b1;
    endcase
    return o;
  endfunction

  function automatic void predict_beat(rth_in_t it);
    case (it.cmd)
      CMD_PUSH: begin
        push_term(it.term);
        n_push++;
      end
      CMD_READ: begin
        expect_beat(read_counter(it.table_select, it.counter_index));
        n_read++;
        return;
      end
      CMD_CLEAR: begin
        clear_stores();
        n_other++;
      end
      default: n_other++;
    endcase
    expect_beat('0);
  endfunction

  // Driver: a beat is taken at the edge where start is high and busy is low.
  always @(posedge clk_i) begin
    if (start && !busy) predict_beat(in_i);
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (start && busy) begin
      start <= 1'b1;
    end else if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
      in_i <= pending_cmds.pop_front();
      start <= 1'b1;
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (expected_reads.size() == 0) begin
        $error("result beat with nothing expected: read_data %h", result_o.read_data);
        errors++;
      end else begin
        rth_out_t e;
        e = expected_reads.pop_front();
        if (result_o.read_data !== e.read_data) begin
          $error("read_data: expected %h, got %h", e.read_data, result_o.read_data);
          errors++;
        end
        if (result_o.index_error !== e.index_error) begin
          $error("index_error: expected %b, got %b", e.index_error, result_o.index_error);
          errors++;
        end
      end
    end
  end

  function automatic rth_in_t mk(rth_cmd_e c, logic [63:0] t, logic [2:0] s, logic [18:0] i);
    rth_in_t it;
    it.cmd = c;
    it.term = t;
    it.table_select = s;
    it.counter_index = i;
    return it;
  endfunction

  function automatic rth_in_t random_cmd();
    rth_in_t it;
    int unsigned p, s;
    it = mk(CMD_PUSH, {$urandom, $urandom}, 3'($urandom), 19'($urandom));
    p = $urandom_range(0, 99);
    if (p < 50) begin
      p = $urandom_range(0, 99);
      if (p < 40) it.term = gen_prev + 64'($signed($urandom_range(0, 2200)) - 1100);
      else if (p < 60) it.term = 64'($signed($urandom_range(0, 600)) - 300);
      else if (p < 70) it.term = {p[0], {63{~p[0]}}} ^ 64'($urandom_range(0, 3));
      gen_prev = it.term;
    end else if (p < 97) begin
      it.cmd = CMD_READ;
      s = $urandom_range(0, 9);
      it.table_select = (s > 7) ? 3'($urandom_range(0, 6)) : s[2:0];
      p = $urandom_range(0, 99);
      if (p < 50) begin
        it.counter_index = 19'(hot_addr[it.table_select == SEL_TTRN ? SEL_TOBS :
                                        it.table_select == SEL_XTRN ? SEL_XOBS :
                                        it.table_select]);
      end else if (p < 80 || it.table_select == SEL_SCALAR) begin
        it.counter_index = 19'($urandom_range(0, 5));
      end
    end else begin
      it.cmd = CMD_NOP;
    end
    return it;
  endfunction

  task automatic write_reg(logic idx, logic [31:0] d);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= d;
    if (idx == CFG_O2_MOD) o2_mod_reg = d[5:0];
    else train_lim_reg = d;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_cmds.size() > 0 || start || busy || expected_reads.size() > 0)
      @(posedge clk_i);
  endtask

  initial begin
    int pct [4];
    logic [31:0] o2_set [4];
    logic [31:0] lim_set [4];
    pct = '{0, 60, 0, 14};
    o2_set = '{32'd3, 32'hFFFF_FFF2, 32'd0, 32'($urandom_range(3, 50))};
    lim_set = '{32'hFFFF_FFFF, 32'd100, 32'd0, $urandom};
    o2_mod_reg = O2_MOD_RST;
    train_lim_reg = '0;
    foreach (hot_addr[i]) hot_addr[i] = 0;
    clear_stores();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int ph = 0; ph < 4; ph++) begin
      wait_idle();
      repeat (10) @(posedge clk_i);
      write_reg(CFG_O2_MOD, o2_set[ph]);
      write_reg(CFG_TRAIN, lim_set[ph]);
      idle_pct = pct[ph];
      if (ph == 0) begin
        queue_cmd(mk(CMD_READ, '0, SEL_SCALAR, SCL_MIN));
        queue_cmd(mk(CMD_READ, '0, SEL_SCALAR, SCL_MAX));
        queue_cmd(mk(CMD_PUSH, 64'd0, '0, '0));
        queue_cmd(mk(CMD_PUSH, 64'h7FFF_FFFF_FFFF_FFFF, '0, '0));
        queue_cmd(mk(CMD_PUSH, 64'h8000_0000_0000_0000, '0, '0));
        queue_cmd(mk(CMD_PUSH, -64'd1, '0, '0));
        queue_cmd(mk(CMD_PUSH, 64'd1022, '0, '0));
        queue_cmd(mk(CMD_PUSH, -64'd1, '0, '0));
        queue_cmd(mk(CMD_PUSH, -64'd211, '0, '0));
        queue_cmd(mk(CMD_READ, '0, SEL_DIFF, 19'd0));
        queue_cmd(mk(CMD_READ, '0, SEL_DIFF, 19'd2046));
        queue_cmd(mk(CMD_READ, '0, SEL_DIFF, 19'd2047));
        queue_cmd(mk(CMD_READ, '0, SEL_MARG, 19'd459));
        queue_cmd(mk(CMD_READ, '0, SEL_MARG, 19'd460));
        queue_cmd(mk(CMD_READ, '0, SEL_TOBS, 19'(TRANS_SPAN - 1)));
        queue_cmd(mk(CMD_READ, '0, SEL_TTRN, 19'(TRANS_SPAN)));
        queue_cmd(mk(CMD_READ, '0, SEL_XOBS, 19'd26));
        queue_cmd(mk(CMD_READ, '0, SEL_XTRN, 19'd27));
        queue_cmd(mk(CMD_READ, '0, 3'd7, 19'h7FFFF));
        queue_cmd(mk(CMD_READ, '0, SEL_SCALAR, 19'd5));
        queue_cmd(mk(CMD_NOP, '1, '1, '1));
        for (int s = 0; s < 5; s++) queue_cmd(mk(CMD_READ, '0, SEL_SCALAR, 19'(s)));
        queue_cmd(mk(CMD_CLEAR, '0, '0, '0));
        queue_cmd(mk(CMD_READ, '0, SEL_SCALAR, SCL_MAX));
        gen_prev = '0;
      end
      for (int n = 0; n < 500; n++) queue_cmd(random_cmd());
    end

    wait_idle();
    repeat (20) @(posedge clk_i);
    $display("Covered %0d pushes, %0d reads and %0d clear or no-op commands", n_push, n_read,
             n_other);
    $display("over four register settings and four sender idling rates.");
    if (errors == 0 && expected_reads.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("Timed out with %0d beats outstanding.", expected_reads.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
